// ===== rtl/lsch_pkg.sv =====
// Package for the limit switch center homing unit: phases, commands, codes.
`default_nettype none
package lsch_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAIT_STOP, PH_SEL_MODE, PH_ZERO_VEL, PH_WAIT_RUN, PH_SEARCH,
        PH_CLEAR_A, PH_MEAS_REV, PH_CLEAR_B, PH_MEAS_FWD, PH_CENTER, PH_STOPPING,
        PH_ZEROING, PH_DONE, PH_FAILED
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE = 3'd0, CMD_STOP = 3'd1, CMD_MODE = 3'd2, CMD_ENABLE = 3'd3,
        CMD_VEL = 3'd4, CMD_ZERO = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_BUSY   = 2'd1;
    localparam logic [1:0] ST_DONE   = 2'd2;
    localparam logic [1:0] ST_FAILED = 2'd3;

    localparam logic [2:0] FR_NONE    = 3'd0;
    localparam logic [2:0] FR_STARTUP = 3'd1;
    localparam logic [2:0] FR_FAULT   = 3'd2;
    localparam logic [2:0] FR_STALE   = 3'd3;
    localparam logic [2:0] FR_TIMEOUT = 3'd4;
    localparam logic [2:0] FR_SEND    = 3'd5;

    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd2;

    localparam logic [2:0] REG_FAST    = 3'd0;
    localparam logic [2:0] REG_SLOW    = 3'd1;
    localparam logic [2:0] REG_REVERSE = 3'd2;
    localparam logic [2:0] REG_CLEAR   = 3'd3;
    localparam logic [2:0] REG_PHASE_TO = 3'd4;
    localparam logic [2:0] REG_START_TO = 3'd5;
    localparam logic [2:0] REG_CONFIRM = 3'd6;
    localparam logic [2:0] REG_RETRY   = 3'd7;

    localparam int CFG_IDX_BITS  = 32;
    localparam int CFG_DATA_BITS = 64;

endpackage
`default_nettype wire

// ===== rtl/lsch_core.sv =====
// Homing sequencer step logic: one feedback beat in, next state and one result out.
`default_nettype none
module lsch_core
    import lsch_pkg::*;
#(
    parameter int POS_BITS   = 32,
    parameter int TIMER_BITS = 16
)
(
    input  wire clk,
    input  wire rst_n,
    input  wire step,
    input  wire action,
    input  wire online,
    input  wire motor_faulted,
    input  wire feedback_fresh,
    input  wire [1:0] motor_mode,
    input  wire signed [POS_BITS-1:0] position,
    input  wire signed [POS_BITS-1:0] velocity,
    input  wire switch_level,
    input  wire send_failed,
    input  wire [30:0] fast_speed,
    input  wire [30:0] slow_speed,
    input  wire [30:0] reverse_travel,
    input  wire [30:0] clearance_travel,
    input  wire [15:0] phase_timeout_ticks,
    input  wire [15:0] startup_timeout_ticks,
    input  wire [7:0] confirm_ticks,
    input  wire [7:0] retry_ticks,
    output logic [2:0] command,
    output logic signed [POS_BITS-1:0] velocity_command,
    output logic [1:0] status,
    output logic [2:0] fail_reason,
    output logic signed [POS_BITS-1:0] reverse_edge_position,
    output logic signed [POS_BITS-1:0] forward_edge_position,
    output logic signed [POS_BITS-1:0] center_position
);

    localparam int W = POS_BITS + 2;
    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

    phase_t phase_reg, phase_next;
    logic dir_reg, dir_next, rev_once_reg, rev_once_next;
    logic pend_reg, pend_next, ref_sw_reg, ref_sw_next;
    logic cneg_reg, cneg_next, chk_reg, chk_next;
    logic [2:0] code_reg, code_next;
    logic [TIMER_BITS-1:0] ptimer_reg, ptimer_next;
    logic [7:0] rtimer_reg, rtimer_next, ctimer_reg, ctimer_next;
    logic signed [POS_BITS-1:0] ref_pos_reg, ref_pos_next;
    logic signed [POS_BITS-1:0] redge_reg, redge_next, fedge_reg, fedge_next;
    logic signed [POS_BITS-1:0] ctgt_reg, ctgt_next;

    // Working values of the step
    cmd_t cmd;
    logic signed [W-1:0] vel;
    logic [2:0] bad;
    logic [TIMER_BITS-1:0] tinc;
    logic [7:0] rinc;
    logic pto, sto;
    logic signed [W-1:0] pos_w, slow_w, fast_w, d_ref, moved, d_clr_ph;
    logic signed [W-1:0] csum, cerr, ctr_err;
    logic neg_ph, moving, clr_ph, clr_b, creached, ph_neg_mb;
    logic signed [POS_BITS-1:0] half;
    logic busy;

    assign pos_w  = W'(position);
    assign slow_w = W'({1'b0, slow_speed});
    assign fast_w = W'({1'b0, fast_speed});
    assign tinc   = (ptimer_reg != TMAX) ? ptimer_reg + 1'b1 : ptimer_reg;
    assign rinc   = (rtimer_reg != 8'hFF) ? rtimer_reg + 8'd1 : rtimer_reg;
    assign pto    = {{(32-TIMER_BITS){1'b0}}, tinc} >= {16'd0, phase_timeout_ticks};
    assign sto    = {{(32-TIMER_BITS){1'b0}}, tinc} >= {16'd0, startup_timeout_ticks};
    assign bad    = (online && motor_faulted) ? FR_FAULT
                  : (!online || motor_faulted || !feedback_fresh) ? FR_STALE : FR_NONE;
    assign busy   = !(phase_reg == PH_IDLE || phase_reg == PH_DONE || phase_reg == PH_FAILED);

    // Clearance distances from the stored reference and from this position
    assign neg_ph   = (phase_reg == PH_MEAS_REV || phase_reg == PH_CLEAR_B) ? !dir_reg : dir_reg;
    assign d_ref    = pos_w - W'(ref_pos_reg);
    assign d_clr_ph = neg_ph ? -d_ref : d_ref;
    assign clr_ph   = d_clr_ph >= $signed(W'({1'b0, clearance_travel}));
    assign clr_b    = W'(0) >= W'({1'b0, clearance_travel});
    assign moved    = d_ref[W-1] ? -d_ref : d_ref;
    assign moving   = neg_ph ? velocity[POS_BITS-1] : (!velocity[POS_BITS-1] && velocity != 0);
    assign ph_neg_mb = !dir_reg;

    // Center from edges, floor of the half sum
    assign csum = W'(redge_reg) + W'(fedge_reg);
    assign half = POS_BITS'(csum >>> 1);
    assign cerr = W'(ctgt_reg) - pos_w;
    assign creached = cneg_reg ? !cerr[W-1] : (cerr[W-1] || cerr == 0);

    always_comb
    begin
        logic [7:0] conf;
        logic neg_c;
        phase_next = phase_reg; dir_next = dir_reg; rev_once_next = rev_once_reg;
        pend_next = pend_reg; ref_sw_next = ref_sw_reg; cneg_next = cneg_reg;
        chk_next = chk_reg; code_next = code_reg; ptimer_next = ptimer_reg;
        rtimer_next = rtimer_reg; ctimer_next = ctimer_reg; ref_pos_next = ref_pos_reg;
        redge_next = redge_reg; fedge_next = fedge_reg; ctgt_next = ctgt_reg;
        cmd = CMD_NONE; vel = '0; ctr_err = '0;
        conf = '0; neg_c = 1'b0;
        if (step)
        begin
            if (action)
            begin
                if (!busy)
                begin
                    redge_next = '0; fedge_next = '0; ctgt_next = '0; code_next = FR_NONE;
                    phase_next = PH_WAIT_STOP; ptimer_next = '0; rtimer_next = '0;
                    cmd = CMD_STOP; chk_next = 1'b0;
                end
            end
            else if (busy)
            begin
                chk_next = 1'b0;
                if (chk_reg && send_failed)
                begin
                    phase_next = PH_FAILED; code_next = FR_SEND; cmd = CMD_STOP;
                end
                else
                begin
                    case (phase_reg)
                        PH_WAIT_STOP:
                        begin
                            ptimer_next = tinc;
                            if (sto)
                            begin
                                phase_next = PH_FAILED; code_next = FR_STARTUP; cmd = CMD_STOP;
                            end
                            else if (online && motor_mode == MODE_STOPPED && feedback_fresh)
                            begin
                                if (motor_faulted)
                                begin
                                    phase_next = PH_FAILED; code_next = FR_FAULT; cmd = CMD_STOP;
                                end
                                else
                                begin
                                    phase_next = PH_SEL_MODE; cmd = CMD_MODE; chk_next = 1'b1;
                                end
                            end
                            else
                            begin
                                rtimer_next = rinc;
                                if (rinc >= retry_ticks)
                                begin
                                    rtimer_next = '0; cmd = CMD_STOP;
                                end
                            end
                        end
                        PH_SEL_MODE:
                        begin
                            phase_next = PH_ZERO_VEL; cmd = CMD_VEL; chk_next = 1'b1;
                        end
                        PH_ZERO_VEL:
                        begin
                            phase_next = PH_WAIT_RUN; ptimer_next = '0; rtimer_next = '0;
                            cmd = CMD_ENABLE; chk_next = 1'b1;
                        end
                        PH_WAIT_RUN:
                        begin
                            ptimer_next = tinc;
                            if (online && motor_faulted)
                            begin
                                phase_next = PH_FAILED; code_next = FR_FAULT; cmd = CMD_STOP;
                            end
                            else if (online && motor_mode == MODE_RUNNING && feedback_fresh)
                            begin
                                phase_next = PH_SEARCH; ref_pos_next = position;
                                ref_sw_next = switch_level; dir_next = 1'b0;
                                rev_once_next = 1'b0; ptimer_next = '0;
                                cmd = CMD_VEL; vel = fast_w; chk_next = 1'b1;
                            end
                            else if (sto)
                            begin
                                phase_next = PH_FAILED; code_next = FR_STARTUP; cmd = CMD_STOP;
                            end
                            else
                            begin
                                rtimer_next = rinc;
                                if (rinc >= retry_ticks)
                                begin
                                    rtimer_next = '0; cmd = CMD_ENABLE; chk_next = 1'b1;
                                end
                            end
                        end
                        PH_SEARCH:
                        begin
                            ptimer_next = tinc;
                            if (switch_level != ref_sw_reg)
                            begin
                                // enter clear A, or meas rev if clearance is 0; ref here
                                if (bad != FR_NONE)
                                begin
                                    phase_next = PH_FAILED; code_next = bad; cmd = CMD_STOP;
                                end
                                else
                                begin
                                    ref_pos_next = position; ptimer_next = '0;
                                    if (clr_b)
                                    begin
                                        phase_next = PH_MEAS_REV; ref_sw_next = switch_level;
                                        pend_next = 1'b0; ctimer_next = '0;
                                        cmd = CMD_VEL; vel = ph_neg_mb ? -slow_w : slow_w;
                                        chk_next = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_CLEAR_A; cmd = CMD_VEL;
                                        vel = dir_reg ? -slow_w : slow_w; chk_next = 1'b1;
                                    end
                                end
                            end
                            else if (bad != FR_NONE)
                            begin
                                phase_next = PH_FAILED; code_next = bad; cmd = CMD_STOP;
                            end
                            else if (pto)
                            begin
                                phase_next = PH_FAILED; code_next = FR_TIMEOUT; cmd = CMD_STOP;
                            end
                            else
                            begin
                                neg_c = dir_reg;
                                if (!rev_once_reg && moved >= W'({1'b0, reverse_travel}))
                                begin
                                    neg_c = !dir_reg; dir_next = !dir_reg; rev_once_next = 1'b1;
                                end
                                cmd = CMD_VEL; vel = neg_c ? -fast_w : fast_w; chk_next = 1'b1;
                            end
                        end
                        PH_CLEAR_A, PH_CLEAR_B:
                        begin
                            ptimer_next = tinc;
                            if (bad != FR_NONE)
                            begin
                                phase_next = PH_FAILED; code_next = bad; cmd = CMD_STOP;
                            end
                            else if (clr_ph)
                            begin
                                // measure phase direction: rev uses !dir, fwd uses dir
                                neg_c = (phase_reg == PH_CLEAR_A) ? !dir_reg : dir_reg;
                                phase_next = (phase_reg == PH_CLEAR_A) ? PH_MEAS_REV : PH_MEAS_FWD;
                                ref_sw_next = switch_level; pend_next = 1'b0;
                                ctimer_next = '0; ptimer_next = '0;
                                cmd = CMD_VEL; vel = neg_c ? -slow_w : slow_w; chk_next = 1'b1;
                            end
                            else if (pto)
                            begin
                                phase_next = PH_FAILED; code_next = FR_TIMEOUT; cmd = CMD_STOP;
                            end
                            else
                            begin
                                cmd = CMD_VEL; vel = neg_ph ? -slow_w : slow_w; chk_next = 1'b1;
                            end
                        end
                        PH_MEAS_REV, PH_MEAS_FWD:
                        begin
                            ptimer_next = tinc;
                            if (pto)
                            begin
                                phase_next = PH_FAILED; code_next = FR_TIMEOUT; cmd = CMD_STOP;
                            end
                            else if (bad != FR_NONE)
                            begin
                                phase_next = PH_FAILED; code_next = bad; cmd = CMD_STOP;
                            end
                            else if (switch_level != ref_sw_reg && moving)
                            begin
                                conf = ctimer_reg;
                                if (!pend_reg)
                                begin
                                    if (phase_reg == PH_MEAS_REV) redge_next = position;
                                    else fedge_next = position;
                                    pend_next = 1'b1; conf = '0;
                                end
                                else if (ctimer_reg != 8'hFF)
                                begin
                                    conf = ctimer_reg + 8'd1;
                                end
                                ctimer_next = conf;
                                if (conf >= confirm_ticks)
                                begin
                                    if (phase_reg == PH_MEAS_REV)
                                    begin
                                        // enter clear B (along !dir) or meas fwd if clr 0
                                        ref_pos_next = position; ptimer_next = '0;
                                        if (clr_b)
                                        begin
                                            phase_next = PH_MEAS_FWD; ref_sw_next = switch_level;
                                            pend_next = 1'b0; ctimer_next = '0;
                                            cmd = CMD_VEL; vel = dir_reg ? -slow_w : slow_w;
                                        end
                                        else
                                        begin
                                            phase_next = PH_CLEAR_B; cmd = CMD_VEL;
                                            vel = !dir_reg ? -slow_w : slow_w;
                                        end
                                        chk_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // edges: reverse from reg, forward as captured
                                        ctgt_next = POS_BITS'((W'(redge_reg) + pos_w) >>> 1);
                                        if (pend_reg)
                                            ctgt_next = half;
                                        ptimer_next = '0; phase_next = PH_CENTER;
                                        ctr_err = W'(ctgt_next) - pos_w;
                                        neg_c = ctr_err[W-1];
                                        cneg_next = neg_c;
                                        if (neg_c ? !ctr_err[W-1] : (ctr_err[W-1] || ctr_err == 0))
                                        begin
                                            phase_next = PH_STOPPING; cmd = CMD_STOP;
                                        end
                                        else
                                        begin
                                            cmd = CMD_VEL; vel = neg_c ? -slow_w : slow_w;
                                        end
                                        chk_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    cmd = CMD_VEL; vel = neg_ph ? -slow_w : slow_w; chk_next = 1'b1;
                                end
                            end
                            else
                            begin
                                pend_next = 1'b0;
                                cmd = CMD_VEL; vel = neg_ph ? -slow_w : slow_w; chk_next = 1'b1;
                            end
                        end
                        PH_CENTER:
                        begin
                            ptimer_next = tinc;
                            if (pto)
                            begin
                                phase_next = PH_FAILED; code_next = FR_TIMEOUT; cmd = CMD_STOP;
                            end
                            else if (bad != FR_NONE)
                            begin
                                phase_next = PH_FAILED; code_next = bad; cmd = CMD_STOP;
                            end
                            else if (creached)
                            begin
                                phase_next = PH_STOPPING; cmd = CMD_STOP; chk_next = 1'b1;
                            end
                            else
                            begin
                                cmd = CMD_VEL; vel = cneg_reg ? -slow_w : slow_w; chk_next = 1'b1;
                            end
                        end
                        PH_STOPPING:
                        begin
                            phase_next = PH_ZEROING; cmd = CMD_ZERO; chk_next = 1'b1;
                        end
                        PH_ZEROING:
                        begin
                            phase_next = PH_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Result fields follow the updated phase
    always_comb
    begin
        case (phase_next)
            PH_IDLE:   status = ST_IDLE;
            PH_DONE:   status = ST_DONE;
            PH_FAILED: status = ST_FAILED;
            default:   status = ST_BUSY;
        endcase
        command = cmd;
        velocity_command = (cmd == CMD_VEL) ? POS_BITS'(vel) : '0;
        fail_reason = (phase_next == PH_FAILED) ? code_next : FR_NONE;
        reverse_edge_position = redge_next;
        forward_edge_position = fedge_next;
        center_position = ctgt_next;
    end

    // Hold state between accepted beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; dir_reg <= 1'b0; rev_once_reg <= 1'b0;
            pend_reg <= 1'b0; ref_sw_reg <= 1'b0; cneg_reg <= 1'b0; chk_reg <= 1'b0;
            code_reg <= FR_NONE; ptimer_reg <= '0; rtimer_reg <= '0; ctimer_reg <= '0;
            ref_pos_reg <= '0; redge_reg <= '0; fedge_reg <= '0; ctgt_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; dir_reg <= dir_next; rev_once_reg <= rev_once_next;
            pend_reg <= pend_next; ref_sw_reg <= ref_sw_next; cneg_reg <= cneg_next;
            chk_reg <= chk_next; code_reg <= code_next; ptimer_reg <= ptimer_next;
            rtimer_reg <= rtimer_next; ctimer_reg <= ctimer_next;
            ref_pos_reg <= ref_pos_next; redge_reg <= redge_next;
            fedge_reg <= fedge_next; ctgt_reg <= ctgt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/limit_switch_center_homing_unit.sv =====
// Top level of the limit switch center homing unit: ports, registers, result buffer.
//
// channel | direction | fields
// s_axis  | in        | tuser: action
//         |           | tdata: online, motor_faulted, feedback_fresh, motor_mode,
//         |           |        position, velocity, switch_level, send_failed
// m_axis  | out       | tdata: command, velocity_command, status, fail_reason,
//         |           |        reverse_edge_position, forward_edge_position, center_position
// cfg     | in        | index, data: register write
//
// One beat per clock. The step logic sits between the input port and a
// one-entry output register; a beat is taken whenever the output register is
// empty or being drained, and its result is offered in the next cycle.
// Reset returns to idle with the register defaults.
// Downstream stalls hold the result and stop intake.
`default_nettype none
module limit_switch_center_homing_unit
    import lsch_pkg::*;
#(
    parameter int POS_BITS   = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TIMER_BITS = 16
)
(
    input  wire clk,
    input  wire rst_n,
    input  wire s_axis_tvalid,
    output logic s_axis_tready,
    // action
    input  wire [0:0] s_axis_tuser,
    // online, motor_faulted, feedback_fresh, motor_mode[2], position, velocity,
    // switch_level, send_failed, zero fill
    input  wire [((2*POS_BITS+7+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  wire m_axis_tready,
    // command[3], velocity_command, status[2], fail_reason[3], reverse_edge_position,
    // forward_edge_position, center_position
    output logic [((4*POS_BITS+8+7)/8)*8-1:0] m_axis_tdata,
    input  wire cfg_valid,
    output logic cfg_ready,
    input  wire [CFG_IDX_BITS-1:0] cfg_index,
    input  wire [CFG_DATA_BITS-1:0] cfg_data
);

    localparam int P = POS_BITS;
    localparam int OW = ((4*POS_BITS+8+7)/8)*8;
    localparam int IW = ((2*POS_BITS+7+7)/8)*8;

    logic [30:0] fast_reg, slow_reg, rev_reg, clr_reg;
    logic [15:0] pto_reg, sto_reg;
    logic [7:0] conf_reg, retry_reg;
    logic out_valid_reg;
    logic [OW-1:0] out_reg;
    logic take;

    logic [2:0] command, fail_reason;
    logic [1:0] status;
    logic signed [P-1:0] vcmd, redge, fedge, ctr;

    assign cfg_ready = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= 31'(64'd1 << FRAC_BITS);
            slow_reg <= 31'((64'd2 << FRAC_BITS) / 5);
            rev_reg  <= 31'((64'd68629 << FRAC_BITS) >> 16);
            clr_reg  <= 31'((64'd2288 << FRAC_BITS) >> 16);
            pto_reg <= 16'd1500; sto_reg <= 16'd300; conf_reg <= 8'd2; retry_reg <= 8'd10;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_IDX_BITS'(REG_FAST))     fast_reg <= cfg_data[30:0];
            if (cfg_index == CFG_IDX_BITS'(REG_SLOW))     slow_reg <= cfg_data[30:0];
            if (cfg_index == CFG_IDX_BITS'(REG_REVERSE))  rev_reg <= cfg_data[30:0];
            if (cfg_index == CFG_IDX_BITS'(REG_CLEAR))    clr_reg <= cfg_data[30:0];
            if (cfg_index == CFG_IDX_BITS'(REG_PHASE_TO)) pto_reg <= cfg_data[15:0];
            if (cfg_index == CFG_IDX_BITS'(REG_START_TO)) sto_reg <= cfg_data[15:0];
            if (cfg_index == CFG_IDX_BITS'(REG_CONFIRM))  conf_reg <= cfg_data[7:0];
            if (cfg_index == CFG_IDX_BITS'(REG_RETRY))    retry_reg <= cfg_data[7:0];
        end
    end

    lsch_core #(.POS_BITS(POS_BITS), .TIMER_BITS(TIMER_BITS)) u_core (
        .clk(clk), .rst_n(rst_n), .step(take),
        .action(s_axis_tuser[0]), .online(s_axis_tdata[0]),
        .motor_faulted(s_axis_tdata[1]), .feedback_fresh(s_axis_tdata[2]),
        .motor_mode(s_axis_tdata[4:3]),
        .position(s_axis_tdata[5 +: P]), .velocity(s_axis_tdata[5+P +: P]),
        .switch_level(s_axis_tdata[5+2*P]), .send_failed(s_axis_tdata[6+2*P]),
        .fast_speed(fast_reg), .slow_speed(slow_reg), .reverse_travel(rev_reg),
        .clearance_travel(clr_reg), .phase_timeout_ticks(pto_reg),
        .startup_timeout_ticks(sto_reg), .confirm_ticks(conf_reg), .retry_ticks(retry_reg),
        .command(command), .velocity_command(vcmd), .status(status),
        .fail_reason(fail_reason), .reverse_edge_position(redge),
        .forward_edge_position(fedge), .center_position(ctr)
    );

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= OW'({ctr, fedge, redge, fail_reason, status, vcmd, command});
    end

    logic unused;
    assign unused = ^{s_axis_tdata[IW-1:7+2*P], cfg_data[CFG_DATA_BITS-1:31], 1'b0};

endmodule
`default_nettype wire
